/* design/nmea_sentence_checker_top_assert.svh */
// Assertion macros for the checker file of the sentence checker.
`ifndef NMEA_SENTENCE_CHECKER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define NSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define NSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/nsc_pkg.sv */
package nsc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_W     = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [7:0] MAX_LEN_RESET = 8'd120;

  // Register index taken from paddr[2].
  localparam logic REG_MAX_LINE_LENGTH = 1'b0;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [23:0] TAIL_RMC = 24'h524D43;
  localparam logic [23:0] TAIL_GGA = 24'h474741;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_RMC   = 2'd1;
  localparam logic [1:0] KIND_GGA   = 2'd2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  typedef struct packed {
    logic                 ok;
    logic [1:0]           kind;
    logic [TOTAL_W-1:0]   good;
    logic [TOTAL_W-1:0]   bad;
  } result_t;

  // Bit 4 flags a byte that is not a hex digit; bits 3:0 hold the value.
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b0, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b0, 4'(b - 8'h37)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b0, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

/* design/nmea_sentence_checker_top.sv */
// NMEA sentence checker: one received byte per transfer, one result per non-empty line.
// Each result is registered in the output register, or in the skid entry under a stall.
// Throughput: one byte every cycle while in_stall is low; the per-byte state update
// is a single pass of XOR, compare and shift logic, and a two-entry result buffer
// absorbs output stalls. Reset (synchronous, active high) clears the line state,
// counters and both result entries, and sets max_line_length to 120.
module nmea_sentence_checker_top (
  input  logic                               clk,
  input  logic                               rst,
  // Byte input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               checksum_ok,
  output logic [1:0]                         sentence_kind,
  output logic [nsc_pkg::TOTAL_W-1:0]        good_total,
  output logic [nsc_pkg::TOTAL_W-1:0]        bad_total,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nsc_pkg::ADDR_W-1:0]         paddr,
  input  logic [nsc_pkg::DATA_W-1:0]         pwdata,
  output logic [nsc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  // Configuration register. Only one register exists, so paddr[2] selects it
  // and the byte-lane bits are not decoded.
  logic [7:0] max_line_length;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nsc_pkg::REG_MAX_LINE_LENGTH)
                  ? {{(nsc_pkg::DATA_W-8){1'b0}}, max_line_length}
                  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= nsc_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nsc_pkg::REG_MAX_LINE_LENGTH) begin
      max_line_length <= pwdata[7:0];
    end
  end

  // Per-line state. Each register has a next value that the byte logic builds.
  logic [7:0]  line_length,        line_length_next;
  logic        starts_with_dollar, starts_with_dollar_next;
  logic [7:0]  xor_sum,            xor_sum_next;
  logic        star_seen,          star_seen_next;
  logic [1:0]  after_star_count,   after_star_count_next;
  logic [7:0]  hex_digits,         hex_digits_next;
  logic        hex_bad,            hex_bad_next;
  logic        nul_seen,           nul_seen_next;
  logic        talker_done,        talker_done_next;
  logic [23:0] talker_tail,        talker_tail_next;
  logic [1:0]  talker_length,      talker_length_next;
  logic [nsc_pkg::COUNT_WIDTH-1:0] good_count, good_count_next;
  logic [nsc_pkg::COUNT_WIDTH-1:0] bad_count,  bad_count_next;

  // Result buffer: the output register, plus a skid entry that catches a result
  // produced while the output register is held by a stall.
  nsc_pkg::result_t out_res, skid_res, res;
  logic             skid_valid;
  logic             res_valid;
  logic             accept;
  logic             out_take;
  logic             line_clear;
  logic             ok;
  logic [4:0]       nib;

  // The skid entry is only ever filled when the output register is full, so
  // holding off input while it is occupied is enough to never lose a result.
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    line_length_next        = line_length;
    starts_with_dollar_next = starts_with_dollar;
    xor_sum_next            = xor_sum;
    star_seen_next          = star_seen;
    after_star_count_next   = after_star_count;
    hex_digits_next         = hex_digits;
    hex_bad_next            = hex_bad;
    nul_seen_next           = nul_seen;
    talker_done_next        = talker_done;
    talker_tail_next        = talker_tail;
    talker_length_next      = talker_length;
    good_count_next         = good_count;
    bad_count_next          = bad_count;
    line_clear              = 1'b0;
    res_valid               = 1'b0;
    ok                      = 1'b0;
    nib                     = nsc_pkg::nibble_of(rx_byte);
    res.ok                  = 1'b0;
    res.kind                = nsc_pkg::KIND_OTHER;

    if (accept && rx_byte != nsc_pkg::CH_CR) begin
      if (rx_byte != nsc_pkg::CH_LF) begin
        if (line_length < max_line_length) begin
          line_length_next = line_length + 8'd1;
          // Once a NUL is seen the rest of the line only counts toward length.
          if (!nul_seen) begin
            if (rx_byte == nsc_pkg::CH_NUL) begin
              nul_seen_next = 1'b1;
            end else if (line_length == 8'd0) begin
              starts_with_dollar_next = (rx_byte == nsc_pkg::CH_DOLLAR);
            end else if (!star_seen) begin
              if (rx_byte == nsc_pkg::CH_STAR) begin
                star_seen_next = 1'b1;
              end else begin
                xor_sum_next = xor_sum ^ rx_byte;
                // The talker field runs up to the first comma or star.
                if (!talker_done) begin
                  if (rx_byte == nsc_pkg::CH_COMMA) begin
                    talker_done_next = 1'b1;
                  end else begin
                    talker_tail_next = {talker_tail[15:0], rx_byte};
                    if (talker_length != 2'd3) begin
                      talker_length_next = talker_length + 2'd1;
                    end
                  end
                end
              end
            end else if (after_star_count != 2'd2) begin
              // A bad digit marks the line and shifts in zero.
              hex_bad_next          = hex_bad | nib[4];
              hex_digits_next       = {hex_digits[3:0], nib[4] ? 4'h0 : nib[3:0]};
              after_star_count_next = after_star_count + 2'd1;
            end
          end
        end else begin
          // The line grew past the limit and is dropped whole.
          line_clear = 1'b1;
        end
      end else if (line_length != 8'd0) begin
        ok = starts_with_dollar && star_seen && after_star_count == 2'd2 &&
             !hex_bad && xor_sum == hex_digits;
        res_valid  = 1'b1;
        line_clear = 1'b1;
        res.ok     = ok;
        if (ok) begin
          good_count_next = good_count + nsc_pkg::count_t'(1);
          if (talker_length == 2'd3 && talker_tail == nsc_pkg::TAIL_RMC) begin
            res.kind = nsc_pkg::KIND_RMC;
          end else if (talker_length == 2'd3 && talker_tail == nsc_pkg::TAIL_GGA) begin
            res.kind = nsc_pkg::KIND_GGA;
          end
        end else begin
          bad_count_next = bad_count + nsc_pkg::count_t'(1);
        end
      end
    end

    if (line_clear) begin
      line_length_next        = '0;
      starts_with_dollar_next = 1'b0;
      xor_sum_next            = '0;
      star_seen_next          = 1'b0;
      after_star_count_next   = '0;
      hex_digits_next         = '0;
      hex_bad_next            = 1'b0;
      nul_seen_next           = 1'b0;
      talker_done_next        = 1'b0;
      talker_tail_next        = '0;
      talker_length_next      = '0;
    end

    // The totals carry the low bits of the counters after this line.
    res.good = nsc_pkg::total_t'(good_count_next);
    res.bad  = nsc_pkg::total_t'(bad_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length        <= '0;
      starts_with_dollar <= 1'b0;
      xor_sum            <= '0;
      star_seen          <= 1'b0;
      after_star_count   <= '0;
      hex_digits         <= '0;
      hex_bad            <= 1'b0;
      nul_seen           <= 1'b0;
      talker_done        <= 1'b0;
      talker_tail        <= '0;
      talker_length      <= '0;
      good_count         <= '0;
      bad_count          <= '0;
    end else begin
      line_length        <= line_length_next;
      starts_with_dollar <= starts_with_dollar_next;
      xor_sum            <= xor_sum_next;
      star_seen          <= star_seen_next;
      after_star_count   <= after_star_count_next;
      hex_digits         <= hex_digits_next;
      hex_bad            <= hex_bad_next;
      nul_seen           <= nul_seen_next;
      talker_done        <= talker_done_next;
      talker_tail        <= talker_tail_next;
      talker_length      <= talker_length_next;
      good_count         <= good_count_next;
      bad_count          <= bad_count_next;
    end
  end

  // Result buffer control. When the output register frees up, the skid entry
  // moves forward first; a new result can only appear when the skid is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_valid) begin
        out_res <= res;
      end
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign checksum_ok   = out_res.ok;
  assign sentence_kind = out_res.kind;
  assign good_total    = out_res.good;
  assign bad_total     = out_res.bad;

endmodule

/* design/nsc_checker.sv */
`include "nmea_sentence_checker_top_assert.svh"

module nsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        checksum_ok,
  input logic [1:0]                  sentence_kind,
  input logic [nsc_pkg::TOTAL_W-1:0] good_total,
  input logic [nsc_pkg::TOTAL_W-1:0] bad_total
);

  logic                              out_fail;
  logic                              kind_other;
  logic                              held;
  logic [2*nsc_pkg::TOTAL_W+2:0]     out_word;

  assign out_fail   = out_valid && !checksum_ok;
  assign kind_other = (sentence_kind == nsc_pkg::KIND_OTHER);
  assign held       = !rst && out_valid && out_stall;
  assign out_word   = {checksum_ok, sentence_kind, good_total, bad_total};

  // A failed sentence never carries a kind.
  `NSC_ASSERT_NOW(a_kind_needs_pass, out_fail, kind_other, "kind set on failed sentence")

  // Input is only held off while a result is waiting at the output.
  `NSC_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid, "input stalled with no result")

  // Reset empties the result buffer and releases the input.
  `NSC_ASSERT_NEXT(a_reset_clears, rst, !out_valid && !in_stall, "reset left a result pending")

  // A stalled result holds its contents.
  `NSC_ASSERT_NEXT(a_out_hold, held, rst || (out_valid && $stable(out_word)), "result not held")

endmodule

bind nmea_sentence_checker_top nsc_checker u_nsc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .checksum_ok   (checksum_ok),
  .sentence_kind (sentence_kind),
  .good_total    (good_total),
  .bad_total     (bad_total)
);

/* verif/nmea_sentence_checker_top_test.sv */
// Scoreboard for the sentence checker. It follows the byte stream the block
// accepts, rebuilds the line state on its own, and queues the result that each
// finished non-empty line should produce. Results leaving the block are then
// compared against the oldest queued line verdict.
class nmea_line_book;
  logic [7:0]             length_limit;
  logic [7:0]             line_len;
  bit                     dollar_first;
  logic [7:0]             running_xor;
  bit                     star_hit;
  logic [1:0]             digits_after_star;
  logic [7:0]             cksum_digits;
  bit                     digit_fault;
  bit                     nul_hit;
  bit                     talker_closed;
  logic [23:0]            talker_last3;
  logic [1:0]             talker_count;
  nsc_pkg::count_t        pass_count;
  nsc_pkg::count_t        fail_count;
  nsc_pkg::result_t       verdicts[$];
  int                     failures;
  int                     lines_checked;
  int                     rmc_lines;
  int                     gga_lines;

  function new();
    length_limit  = nsc_pkg::MAX_LEN_RESET;
    pass_count    = '0;
    fail_count    = '0;
    failures      = 0;
    lines_checked = 0;
    rmc_lines     = 0;
    gga_lines     = 0;
    restart_line();
  endfunction

  function void restart_line();
    line_len          = '0;
    dollar_first      = 1'b0;
    running_xor       = '0;
    star_hit          = 1'b0;
    digits_after_star = '0;
    cksum_digits      = '0;
    digit_fault       = 1'b0;
    nul_hit           = 1'b0;
    talker_closed     = 1'b0;
    talker_last3      = '0;
    talker_count      = '0;
  endfunction

  function void set_limit(logic [7:0] value);
    length_limit = value;
  endfunction

  function int pending();
    return verdicts.size();
  endfunction

  // Called for every byte transfer the block accepts.
  function void note_byte(logic [7:0] b);
    logic [4:0]       digit;
    bit               passed;
    nsc_pkg::result_t verdict;
    if (b == nsc_pkg::CH_CR) return;
    if (b != nsc_pkg::CH_LF) begin
      if (line_len >= length_limit) begin
        restart_line();
        return;
      end
      if (!nul_hit) begin
        if (b == nsc_pkg::CH_NUL) begin
          nul_hit = 1'b1;
        end else if (line_len == 8'd0) begin
          dollar_first = (b == nsc_pkg::CH_DOLLAR);
        end else if (!star_hit) begin
          if (b == nsc_pkg::CH_STAR) begin
            star_hit = 1'b1;
          end else begin
            running_xor ^= b;
            if (!talker_closed) begin
              if (b == nsc_pkg::CH_COMMA) begin
                talker_closed = 1'b1;
              end else begin
                talker_last3 = {talker_last3[15:0], b};
                if (talker_count != 2'd3) talker_count++;
              end
            end
          end
        end else if (digits_after_star != 2'd2) begin
          // Bit 4 marks a non-hex byte; such a byte shifts in as zero.
          digit = 5'h10;
          if (b >= "0" && b <= "9") digit = {1'b0, 4'(b - "0")};
          if (b >= "A" && b <= "F") digit = {1'b0, 4'(b - "A" + 8'd10)};
          if (b >= "a" && b <= "f") digit = {1'b0, 4'(b - "a" + 8'd10)};
          digit_fault |= digit[4];
          cksum_digits = {cksum_digits[3:0], digit[3:0]};
          digits_after_star++;
        end
      end
      line_len++;
      return;
    end
    if (line_len == 8'd0) return;
    passed = dollar_first && star_hit && digits_after_star == 2'd2 && !digit_fault &&
             running_xor == cksum_digits;
    verdict.kind = nsc_pkg::KIND_OTHER;
    if (passed) begin
      pass_count++;
      if (talker_count == 2'd3 && talker_last3 == nsc_pkg::TAIL_RMC) begin
        verdict.kind = nsc_pkg::KIND_RMC;
        rmc_lines++;
      end else if (talker_count == 2'd3 && talker_last3 == nsc_pkg::TAIL_GGA) begin
        verdict.kind = nsc_pkg::KIND_GGA;
        gga_lines++;
      end
    end else begin
      fail_count++;
    end
    verdict.ok   = passed;
    verdict.good = nsc_pkg::total_t'(pass_count);
    verdict.bad  = nsc_pkg::total_t'(fail_count);
    verdicts.push_back(verdict);
    restart_line();
  endfunction

  // Called for every result transfer the block delivers.
  function void check_line(nsc_pkg::result_t got);
    nsc_pkg::result_t want;
    if (verdicts.size() == 0) begin
      $display("%0t: unexpected result ok=%0b kind=%0d good=%0d bad=%0d", $time,
               got.ok, got.kind, got.good, got.bad);
      failures++;
      return;
    end
    want = verdicts.pop_front();
    lines_checked++;
    if (got.ok !== want.ok) begin
      $display("%0t: checksum_ok expected %0b, got %0b", $time, want.ok, got.ok);
      failures++;
    end
    if (got.kind !== want.kind) begin
      $display("%0t: sentence_kind expected %0d, got %0d", $time, want.kind, got.kind);
      failures++;
    end
    if (got.good !== want.good) begin
      $display("%0t: good_total expected %0d, got %0d", $time, want.good, got.good);
      failures++;
    end
    if (got.bad !== want.bad) begin
      $display("%0t: bad_total expected %0d, got %0d", $time, want.bad, got.bad);
      failures++;
    end
  endfunction
endclass

module nmea_sentence_checker_top_test;

  // The only register sits at byte address zero; bit 2 of the address selects
  // the register, the two low bits are the byte offset.
  localparam logic [nsc_pkg::ADDR_W-1:0] ADDR_MAX_LEN =
    {nsc_pkg::REG_MAX_LINE_LENGTH, 2'b00};
  // Length of the long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 100;
  // Generous upper bound on the whole run, in time units (12 per cycle).
  localparam int RUN_LIMIT = 6000000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   rx_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         checksum_ok;
  logic [1:0]                   sentence_kind;
  logic [nsc_pkg::TOTAL_W-1:0]  good_total;
  logic [nsc_pkg::TOTAL_W-1:0]  bad_total;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [nsc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [nsc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [nsc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  nmea_line_book book;

  // Bytes of the line currently being assembled, the running XOR of its body,
  // and where its '*' was placed (used by the corruption step).
  logic [7:0] line_out[$];
  logic [7:0] body_xor;
  int         star_pos;
  int         bytes_sent = 0;

  // Idling controls. The sender and receiver insert random gaps only while
  // their flag is set; hold_request asks the receiver for one long stall.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_request = 1'b0;

  nmea_sentence_checker_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .checksum_ok   (checksum_ok),
    .sentence_kind (sentence_kind),
    .good_total    (good_total),
    .bad_total     (bad_total),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk = ~clk;

  // All sampling happens at the rising edge, where the testbench still sees the
  // values the block saw. The input transfer is noted before the result check,
  // so the ordering inside one edge never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) book.note_byte(rx_byte);
      if (out_valid && !out_stall) begin
        book.check_line({checksum_ok, sentence_kind, good_total, bad_total});
      end
    end
  end

  // Receiver side: random stall bursts while enabled, plus one long hold-off
  // on request. The hold-off is counted here so the sender keeps pushing.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one byte and returns at the edge where the transfer happens. Valid
  // stays high when no gap follows, so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    if (b != nsc_pkg::CH_CR) bytes_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Lowers valid and waits until every queued verdict has been matched. The
  // extra edges at the end add margin after the last result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_limit(input logic [7:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_LEN;
    pwdata  <= {{(nsc_pkg::DATA_W-8){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.set_limit(value);
    @(posedge clk);
  endtask

  function automatic void put_byte(input logic [7:0] b);
    line_out.push_back(b);
  endfunction

  // Appends a byte that belongs to the checksummed body.
  function automatic void put_summed(input logic [7:0] b);
    line_out.push_back(b);
    body_xor ^= b;
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_out.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return (lower ? 8'("a") : 8'("A")) + 8'(n - 4'd10);
  endfunction

  // Appends "$<body>*hh" with a correct checksum.
  function automatic void put_sentence(input string body, input bit lower);
    body_xor = '0;
    put_byte(nsc_pkg::CH_DOLLAR);
    for (int i = 0; i < body.len(); i++) put_summed(body[i]);
    put_byte(nsc_pkg::CH_STAR);
    put_byte(hex_char(body_xor[7:4], lower));
    put_byte(hex_char(body_xor[3:0], lower));
  endfunction

  // Terminates the assembled line and sends every byte of it.
  task automatic finish_line(input bit with_cr);
    if (with_cr) put_byte(nsc_pkg::CH_CR);
    put_byte(nsc_pkg::CH_LF);
    foreach (line_out[i]) send_byte(line_out[i]);
    line_out.delete();
  endtask

  // Builds a well-formed sentence (without terminator) with random content.
  // When bad_sum is set the checksum digits are off by a nonzero XOR.
  task automatic build_sentence(input bit bad_sum);
    string      talker;
    int         n_fields;
    logic [7:0] c;
    logic [7:0] sum_out;
    line_out.delete();
    body_xor = '0;
    put_byte(nsc_pkg::CH_DOLLAR);
    case ($urandom_range(0, 8))
      0: talker = "GPRMC";
      1: talker = "GNRMC";
      2: talker = "GPGGA";
      3: talker = "GLGGA";
      4: talker = "RMC";
      5: talker = "GGA";
      6: talker = "GPGSV";
      7: talker = "GGAX";
      default: talker = "";
    endcase
    for (int i = 0; i < talker.len(); i++) put_summed(talker[i]);
    // Random talkers of 0 to 6 letters exercise the three-letter tail window.
    if (talker.len() == 0) begin
      repeat ($urandom_range(0, 6)) put_summed(8'($urandom_range(8'h41, 8'h5A)));
    end
    n_fields = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
    for (int f = 0; f < n_fields; f++) begin
      put_summed(nsc_pkg::CH_COMMA);
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == nsc_pkg::CH_STAR) c = nsc_pkg::CH_COMMA;
        put_summed(c);
      end
    end
    star_pos = line_out.size();
    put_byte(nsc_pkg::CH_STAR);
    sum_out = bad_sum ? body_xor ^ 8'($urandom_range(1, 255)) : body_xor;
    put_byte(hex_char(sum_out[7:4], 1'($urandom_range(0, 1))));
    put_byte(hex_char(sum_out[3:0], 1'($urandom_range(0, 1))));
    // Trailing bytes after the digits must not affect the verdict.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
    end
  endtask

  // One random line: mostly clean sentences, then damaged sentences, raw noise
  // over the full byte range, and bare line ends.
  task automatic random_line();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 62) begin
      build_sentence($urandom_range(0, 9) == 0);
    end else if (roll < 80) begin
      build_sentence(1'b0);
      case ($urandom_range(0, 6))
        0: line_out[0] = 8'($urandom_range(0, 255));
        1: line_out.delete(line_out.size() - 1);
        2: line_out.insert($urandom_range(0, line_out.size() - 1), nsc_pkg::CH_NUL);
        3: line_out[$urandom_range(0, line_out.size() - 1)] = 8'($urandom_range(0, 255));
        4: line_out[star_pos + $urandom_range(1, 2)] = 8'($urandom_range(8'h67, 8'h7A));
        5: line_out.insert($urandom_range(1, star_pos), nsc_pkg::CH_STAR);
        default: line_out.delete(star_pos);
      endcase
    end else if (roll < 92) begin
      line_out.delete();
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      line_out.delete();
    end
    finish_line(1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(input int byte_budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) random_line();
  endtask

  // Directed lines at the reset limit of 120: every sentence kind, both digit
  // cases, and each of the framing and checksum failure modes.
  task automatic directed_lines();
    // Clean RMC with upper-case digits and a CR before LF.
    put_sentence("GPRMC,123519,A", 1'b0);
    finish_line(1'b1);
    // Clean GGA with lower-case digits.
    put_sentence("GNGGA,1", 1'b1);
    finish_line(1'b0);
    // Other talker, exactly three letters, and a two-letter talker.
    put_sentence("GPGSV", 1'b0);
    finish_line(1'b0);
    put_sentence("RMC", 1'b0);
    finish_line(1'b0);
    put_sentence("MC", 1'b1);
    finish_line(1'b0);
    // Empty body passes with kind other.
    put_sentence("", 1'b0);
    finish_line(1'b0);
    // Empty lines give no result at all.
    finish_line(1'b0);
    finish_line(1'b1);
    // Missing dollar, wrong checksum, one digit only, no star, non-hex digit.
    put_text("XGPGGA*00");
    finish_line(1'b0);
    put_text("$GPGGA*00");
    finish_line(1'b0);
    put_text("$GPRMC*5");
    finish_line(1'b0);
    put_text("$GPRMC");
    finish_line(1'b0);
    put_text("$A*4G");
    finish_line(1'b0);
    // Trailing text after the digits is ignored.
    put_sentence("GPGGA", 1'b0);
    put_text("junk");
    finish_line(1'b0);
    // A NUL after the digits hides the rest; a NUL in front or inside the
    // body makes the line fail.
    put_sentence("GNRMC", 1'b1);
    put_byte(nsc_pkg::CH_NUL);
    put_text("zz*");
    finish_line(1'b0);
    put_byte(nsc_pkg::CH_NUL);
    put_sentence("GPRMC", 1'b0);
    finish_line(1'b0);
    put_text("$GP");
    put_byte(nsc_pkg::CH_NUL);
    put_text("*17");
    finish_line(1'b0);
    // All-ones body byte, and a lone dollar.
    body_xor = '0;
    put_byte(nsc_pkg::CH_DOLLAR);
    put_summed(8'hFF);
    put_text("*FF");
    finish_line(1'b0);
    put_text("$");
    finish_line(1'b0);
  endtask

  // A line of exactly 255 bytes, then one of 256 which is dropped whole.
  task automatic longest_lines();
    for (int extra = 0; extra < 2; extra++) begin
      body_xor = '0;
      put_byte(nsc_pkg::CH_DOLLAR);
      repeat (248) put_summed("A");
      put_byte(nsc_pkg::CH_STAR);
      put_byte(hex_char(body_xor[7:4], 1'b0));
      put_byte(hex_char(body_xor[3:0], 1'b0));
      repeat (3 + extra) put_byte("x");
      finish_line(1'b0);
    end
  endtask

  initial begin
    book = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limit of 120, no idling first, then with idling on both sides.
    directed_lines();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    directed_lines();

    // Widest limit: boundary lengths, then random traffic with long lines.
    write_limit(8'd255);
    longest_lines();
    random_phase(120);

    // Limit of one: only a single byte survives per line.
    write_limit(8'd1);
    put_text("$");
    finish_line(1'b0);
    put_text("$*00");
    finish_line(1'b0);
    random_phase(40);

    // Zero limit: every byte except CR and LF is dropped, so no results.
    write_limit(8'd0);
    put_sentence("GPRMC", 1'b0);
    finish_line(1'b1);
    random_phase(30);

    // Short limit: many sentences overflow and restart mid-line.
    write_limit(8'd16);
    random_phase(80);

    // Standard sentence length.
    write_limit(8'd82);
    random_phase(110);

    // Long receiver hold-off while the sender keeps offering clean sentences
    // with no gaps, so the result buffer fills and the input stalls.
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (12) begin
      build_sentence(1'b0);
      finish_line(1'b0);
    end
    tx_idle_on = 1'b1;

    // Sender pauses until every expected result has been delivered.
    wait_idle();
    random_phase(80);

    // Last stretch at full rate on both sides.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(100);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d bytes and %0d finished lines (%0d RMC, %0d GGA passes),",
             bytes_sent, book.lines_checked, book.rmc_lines, book.gga_lines);
    $display("with line limits from 0 to 255, stalls on both sides and a long hold-off.");
    if (book.failures == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d results still expected.", book.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
